### rtl/core/sddf_pkg.sv
// Package for the signed decimal display formatter.
// Holds the field widths, the display codes, the flag struct and the BCD helpers.
// No dependencies.
package sddf_pkg;

    localparam int VALUE_W        = 32;
    localparam int NUM_DIGITS     = 8;
    localparam int CODE_W         = 4;
    localparam int BCD_W          = NUM_DIGITS * CODE_W;
    localparam int DAB_STAGES     = 4;
    localparam int BITS_PER_STAGE = VALUE_W / DAB_STAGES;

    localparam logic [VALUE_W-1:0] BLANK_LIMIT   = 32'd999999999;
    localparam logic [VALUE_W-1:0] MILLION_MARK  = 32'd1000000;
    localparam logic [VALUE_W-1:0] THOUSAND_MARK = 32'd1000;
    localparam logic [CODE_W-1:0]  BLANK_CODE    = 4'd10;

    typedef logic [BCD_W-1:0]  t_bcd;
    typedef logic [CODE_W-1:0] t_code;

    typedef struct packed {
        logic                  neg;
        logic                  over;
        logic [NUM_DIGITS-1:0] lead;   // position i lies above every nonzero digit
        logic                  dot_m;
        logic                  dot_t;
    } t_flags;

    // 10**n, evaluated with constant arguments only
    function automatic logic [VALUE_W-1:0] pow10(input int n);
        logic [VALUE_W-1:0] p;
        p = 32'd1;
        for (int j = 0; j < n; j++) begin
            p = p * 32'd10;
        end
        return p;
    endfunction

    // One shift-and-add-3 step; the top digit's carry drops out,
    // which leaves the low digits exact.
    function automatic t_bcd dabble_step(input t_bcd b, input logic bit_in);
        t_bcd t;
        t = b;
        for (int d = 0; d < NUM_DIGITS; d++) begin
            if (t[d*CODE_W +: CODE_W] >= 4'd5) begin
                t[d*CODE_W +: CODE_W] = t[d*CODE_W +: CODE_W] + 4'd3;
            end
        end
        return {t[BCD_W-2:0], bit_in};
    endfunction

endpackage

### rtl/core/signed_decimal_display_formatter_top.sv
// Signed decimal display formatter, top level.
// Pipelined binary-to-BCD conversion with leading-zero blanking.
// Depends on sddf_pkg.
//
// Usage:
//   Input channel: i_valid / o_stall with i_value, a signed 32-bit number.
//   Output channel: o_valid / i_stall with eight digit codes (0-9, 10 blank),
//   the minus sign and the two separator dots.
//   A transaction moves on a clock edge with valid high and stall low.
//   An input transaction reaches o_valid through one
//   magnitude stage, four double-dabble stages of 8 bits each and one
//   output formatting stage.
//   Throughput: one transaction per cycle while the receiver does not stall.
//   Values above 999999999 blank the whole display. Position 0 always
//   shows its digit unless the value is blanked.
//   Reset (synchronous, active low) clears every stage valid bit; payload
//   registers are not reset.
//   When the receiver stalls while a result is held, the whole pipeline
//   freezes, o_stall rises and the held result stays unchanged.
module signed_decimal_display_formatter_top
    import sddf_pkg::*;
(
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_valid,
    output logic                      o_stall,
    input  logic signed [VALUE_W-1:0] i_value,
    output logic                      o_valid,
    input  logic                      i_stall,
    output logic [CODE_W-1:0]         o_digit_units,
    output logic [CODE_W-1:0]         o_digit_tens,
    output logic [CODE_W-1:0]         o_digit_hundreds,
    output logic [CODE_W-1:0]         o_digit_thousands,
    output logic [CODE_W-1:0]         o_digit_ten_thousands,
    output logic [CODE_W-1:0]         o_digit_hundred_thousands,
    output logic [CODE_W-1:0]         o_digit_millions,
    output logic [CODE_W-1:0]         o_digit_ten_millions,
    output logic                      o_minus_sign,
    output logic                      o_dot_millions,
    output logic                      o_dot_thousands
);

    localparam int OUT_ST = DAB_STAGES + 1;

    logic               r_vld [0:OUT_ST];
    logic [VALUE_W-1:0] r_rem [0:DAB_STAGES];
    t_flags             r_flg [0:DAB_STAGES];
    t_bcd               r_bcd [1:DAB_STAGES];
    t_code              r_dig [0:NUM_DIGITS-1];
    logic               r_minus;
    logic               r_dot_m;
    logic               r_dot_t;

    logic               adv;
    logic [VALUE_W-1:0] n_rem0;
    t_flags             n_flg0;
    t_flags             n_flg1;
    t_code              n_dig [0:NUM_DIGITS-1];

    // whole pipe moves unless a held result is stalled
    assign adv     = !(r_vld[OUT_ST] && i_stall);
    assign o_stall = !adv;
    assign o_valid = r_vld[OUT_ST];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int s = 0; s <= OUT_ST; s++) begin
                r_vld[s] <= 1'b0;
            end
        end else if (adv) begin
            r_vld[0] <= i_valid;
            for (int s = 1; s <= OUT_ST; s++) begin
                r_vld[s] <= r_vld[s-1];
            end
        end
    end

    // stage 0: sign and magnitude
    always_comb begin
        n_flg0      = '0;
        n_flg0.neg  = i_value[VALUE_W-1];
        n_flg0.over = !i_value[VALUE_W-1] && (i_value > $signed(BLANK_LIMIT));
        n_rem0      = i_value[VALUE_W-1] ? (~i_value + 32'd1) : i_value;
    end

    // stage 1 flags: thresholds on the full magnitude
    always_comb begin
        n_flg1       = r_flg[0];
        n_flg1.lead  = '0;
        for (int i = 1; i < NUM_DIGITS; i++) begin
            n_flg1.lead[i] = r_rem[0] < pow10(i);
        end
        n_flg1.dot_m = r_rem[0] > MILLION_MARK;
        n_flg1.dot_t = r_rem[0] > THOUSAND_MARK;
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_rem[0] <= n_rem0;
            r_flg[0] <= n_flg0;
            r_flg[1] <= n_flg1;
            for (int s = 2; s <= DAB_STAGES; s++) begin
                r_flg[s] <= r_flg[s-1];
            end
        end
    end

    // stages 1..DAB_STAGES: double dabble, BITS_PER_STAGE bits per stage
    for (genvar k = 1; k <= DAB_STAGES; k++) begin : g_dab
        t_bcd               bcd_in;
        t_bcd               n_bcd;
        logic [VALUE_W-1:0] n_rem;

        if (k == 1) begin : g_first
            assign bcd_in = '0;
        end else begin : g_rest
            assign bcd_in = r_bcd[k-1];
        end

        always_comb begin
            n_bcd = bcd_in;
            for (int b = 0; b < BITS_PER_STAGE; b++) begin
                n_bcd = dabble_step(n_bcd, r_rem[k-1][VALUE_W-1-b]);
            end
            n_rem = r_rem[k-1] << BITS_PER_STAGE;
        end

        always_ff @(posedge i_clk) begin
            if (adv) begin
                r_bcd[k] <= n_bcd;
                r_rem[k] <= n_rem;
            end
        end
    end

    // output stage: blanking and code selection
    always_comb begin
        for (int i = 0; i < NUM_DIGITS; i++) begin
            if (r_flg[DAB_STAGES].over || r_flg[DAB_STAGES].lead[i]) begin
                n_dig[i] = BLANK_CODE;
            end else begin
                n_dig[i] = r_bcd[DAB_STAGES][i*CODE_W +: CODE_W];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            for (int i = 0; i < NUM_DIGITS; i++) begin
                r_dig[i] <= n_dig[i];
            end
            r_minus <= r_flg[DAB_STAGES].neg   && !r_flg[DAB_STAGES].over;
            r_dot_m <= r_flg[DAB_STAGES].dot_m && !r_flg[DAB_STAGES].over;
            r_dot_t <= r_flg[DAB_STAGES].dot_t && !r_flg[DAB_STAGES].over;
        end
    end

    assign o_digit_units             = r_dig[0];
    assign o_digit_tens              = r_dig[1];
    assign o_digit_hundreds          = r_dig[2];
    assign o_digit_thousands         = r_dig[3];
    assign o_digit_ten_thousands     = r_dig[4];
    assign o_digit_hundred_thousands = r_dig[5];
    assign o_digit_millions          = r_dig[6];
    assign o_digit_ten_millions      = r_dig[7];
    assign o_minus_sign              = r_minus;
    assign o_dot_millions            = r_dot_m;
    assign o_dot_thousands           = r_dot_t;

    // blank units only happens for an overflowed value: all else dark
    a_over_dark: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && (o_digit_units == BLANK_CODE) |->
            (o_digit_ten_millions == BLANK_CODE) && !o_minus_sign && !o_dot_thousands)
        else $error("units blank without full blanking");

    // leading blanking never leaves the tens position blank below a lit hundreds digit
    a_lead_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && (o_digit_tens == BLANK_CODE) |-> (o_digit_hundreds == BLANK_CODE))
        else $error("digit shown above a blanked tens position");

    a_dots: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_dot_millions |-> o_dot_thousands)
        else $error("millions dot without thousands dot");

    a_dot_digit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_dot_thousands |-> (o_digit_thousands != BLANK_CODE))
        else $error("thousands dot lit over blank thousands digit");

endmodule
